// File: hdl/ohi_pkg.sv
// shared types, constants and helpers for the open addressing hash insert block
`timescale 1ns / 1ps
package ohi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_CHARS = 9;
    localparam int TAG_BITS = 16;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int SIZE_W = 11;
    localparam int PROD_W = SIZE_W + 8;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] REG_PROBE_MODE = 2'd0;
    localparam logic [1:0] REG_TABLE_SIZE = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE = 2'd2;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 11'd1021;
    localparam logic [SIZE_W-1:0] STEP_SIZE_RST = 11'd509;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_MOD,
        F_STRIDE,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_SWEEP,
        B_IDLE,
        B_PROBE_RD,
        B_PROBE_CHK,
        B_READ_WAIT,
        B_READ_DONE
    } back_state_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]          op;
        logic [63:0]         key_low;
        logic [7:0]          key_high;
        logic [3:0]          key_length;
        logic [TAG_BITS-1:0] record_tag;
        logic [ADDR_W-1:0]   read_slot;
        logic [ADDR_W-1:0]   home_hash;
        logic [ADDR_W-1:0]   inc;
        logic [ADDR_W-1:0]   inc_step;
        logic [SIZE_W-1:0]   tsize;
    } cmd_t;

    typedef struct packed {
        logic [63:0]         key_low;
        logic [7:0]          key_high;
        logic [3:0]          key_length;
        logic [TAG_BITS-1:0] record_tag;
        logic [ADDR_W-1:0]   home_hash;
    } entry_t;

    // first field in the highest bits
    typedef struct packed {
        logic [15:0] stored_tag;
        logic [3:0]  stored_length;
        logic [7:0]  stored_key_high;
        logic [63:0] stored_key_low;
        logic        occupied_flag;
        logic        placed;
        logic [10:0] probes;
        logic [9:0]  home_hash;
        logic [9:0]  slot_index;
    } result_t;

    // one step of restoring remainder
    function automatic logic [SIZE_W-1:0] mod_step(input logic [SIZE_W-1:0] rem,
                                                   input logic b,
                                                   input logic [SIZE_W-1:0] m);
        logic [SIZE_W:0] r2;
        r2 = {rem, b};
        if (r2 >= {1'b0, m})
        begin
            r2 = r2 - {1'b0, m};
        end
        return r2[SIZE_W-1:0];
    endfunction

endpackage

// File: hdl/ohi_front.sv
// front end: accepts items, computes home hash and probe increments
`timescale 1ns / 1ps
module ohi_front
    import ohi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_op,
    input  logic [63:0]       in_key_low,
    input  logic [7:0]        in_key_high,
    input  logic [3:0]        in_key_length,
    input  logic [15:0]       in_record_tag,
    input  logic [9:0]        in_read_slot,
    input  logic              probe_mode,
    input  logic [SIZE_W-1:0] table_size,
    input  logic [SIZE_W-1:0] step_size,
    output logic              q_push,
    output cmd_t              q_data,
    input  logic              q_full
);

    front_state_t state_reg, state_next;

    logic [1:0]          op_reg, op_next;
    logic [63:0]         key_low_reg, key_low_next;
    logic [7:0]          key_high_reg, key_high_next;
    logic [3:0]          len_reg, len_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [ADDR_W-1:0]   rslot_reg, rslot_next;
    logic [71:0]         char_sr_reg, char_sr_next;
    logic [3:0]          n_reg, n_next;
    logic [SIZE_W-1:0]   t_reg, t_next;
    logic [SIZE_W-1:0]   s_reg, s_next;
    logic                mode_reg, mode_next;
    logic [SIZE_W-1:0]   acc_t_reg, acc_t_next;
    logic [SIZE_W-1:0]   acc_s_reg, acc_s_next;
    logic [PROD_W-1:0]   prod_t_reg, prod_t_next;
    logic [PROD_W-1:0]   prod_s_reg, prod_s_next;
    logic [SIZE_W-1:0]   rem_t_reg, rem_t_next;
    logic [SIZE_W-1:0]   rem_s_reg, rem_s_next;
    logic [4:0]          bit_reg, bit_next;
    logic [ADDR_W-1:0]   stride_reg, stride_next;

    logic [SIZE_W-1:0] rem_t_step;
    logic [SIZE_W-1:0] rem_s_step;

    assign rem_t_step = mod_step(rem_t_reg, prod_t_reg[PROD_W-1], t_reg);
    assign rem_s_step = mod_step(rem_s_reg, prod_s_reg[PROD_W-1], s_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_op == OP_INSERT) ? F_MUL : F_PUSH;
                end
            end
            F_MUL:
            begin
                state_next = (n_reg == len_reg) ? F_STRIDE : F_MOD;
            end
            F_MOD:
            begin
                if (bit_reg == 5'd0)
                begin
                    state_next = F_MUL;
                end
            end
            F_STRIDE:
            begin
                if (bit_reg == 5'd0)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next = op_reg;
        key_low_next = key_low_reg;
        key_high_next = key_high_reg;
        len_next = len_reg;
        tag_next = tag_reg;
        rslot_next = rslot_reg;
        char_sr_next = char_sr_reg;
        n_next = n_reg;
        t_next = t_reg;
        s_next = s_reg;
        mode_next = mode_reg;
        acc_t_next = acc_t_reg;
        acc_s_next = acc_s_reg;
        prod_t_next = prod_t_reg;
        prod_s_next = prod_s_reg;
        rem_t_next = rem_t_reg;
        rem_s_next = rem_s_reg;
        bit_next = bit_reg;
        stride_next = stride_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = in_op;
                    key_low_next = in_key_low;
                    key_high_next = in_key_high;
                    len_next = (in_key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS)
                                                               : in_key_length;
                    tag_next = in_record_tag;
                    rslot_next = in_read_slot;
                    char_sr_next = {in_key_high, in_key_low};
                    n_next = 4'd0;
                    if (table_size < SIZE_W'(2))
                    begin
                        t_next = SIZE_W'(2);
                    end
                    else if (table_size > SIZE_W'(TABLE_DEPTH))
                    begin
                        t_next = SIZE_W'(TABLE_DEPTH);
                    end
                    else
                    begin
                        t_next = table_size;
                    end
                    s_next = (step_size < SIZE_W'(2)) ? SIZE_W'(2) : step_size;
                    mode_next = probe_mode;
                    acc_t_next = SIZE_W'(1);
                    acc_s_next = SIZE_W'(1);
                end
            end
            F_MUL:
            begin
                rem_t_next = '0;
                rem_s_next = '0;
                bit_next = 5'(PROD_W - 1);
                if (n_reg == len_reg)
                begin
                    // stride = step_size - (product mod step_size), then reduced mod t
                    prod_t_next = PROD_W'(s_reg - acc_s_reg);
                end
                else
                begin
                    prod_t_next = acc_t_reg * char_sr_reg[7:0];
                    prod_s_next = acc_s_reg * char_sr_reg[7:0];
                end
            end
            F_MOD:
            begin
                rem_t_next = rem_t_step;
                rem_s_next = rem_s_step;
                prod_t_next = {prod_t_reg[PROD_W-2:0], 1'b0};
                prod_s_next = {prod_s_reg[PROD_W-2:0], 1'b0};
                bit_next = bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    acc_t_next = rem_t_step;
                    acc_s_next = rem_s_step;
                    n_next = n_reg + 4'd1;
                    char_sr_next = {8'd0, char_sr_reg[71:8]};
                end
            end
            F_STRIDE:
            begin
                rem_t_next = rem_t_step;
                prod_t_next = {prod_t_reg[PROD_W-2:0], 1'b0};
                bit_next = bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    stride_next = rem_t_step[ADDR_W-1:0];
                end
            end
            F_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == F_IDLE);
        q_push = (state_reg == F_PUSH) && !q_full;
        q_data.op = op_reg;
        q_data.key_low = key_low_reg;
        q_data.key_high = key_high_reg;
        q_data.key_length = len_reg;
        q_data.record_tag = tag_reg;
        q_data.read_slot = rslot_reg;
        q_data.home_hash = acc_t_reg[ADDR_W-1:0];
        q_data.tsize = t_reg;
        if (mode_reg)
        begin
            q_data.inc = stride_reg;
            q_data.inc_step = '0;
        end
        else
        begin
            // quadratic: offsets grow by 1, 3, 5, ... kept mod t
            q_data.inc = ADDR_W'(1);
            q_data.inc_step = (t_reg == SIZE_W'(2)) ? '0 : ADDR_W'(2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        key_low_reg <= key_low_next;
        key_high_reg <= key_high_next;
        len_reg <= len_next;
        tag_reg <= tag_next;
        rslot_reg <= rslot_next;
        char_sr_reg <= char_sr_next;
        n_reg <= n_next;
        t_reg <= t_next;
        s_reg <= s_next;
        mode_reg <= mode_next;
        acc_t_reg <= acc_t_next;
        acc_s_reg <= acc_s_next;
        prod_t_reg <= prod_t_next;
        prod_s_reg <= prod_s_next;
        rem_t_reg <= rem_t_next;
        rem_s_reg <= rem_s_next;
        bit_reg <= bit_next;
        stride_reg <= stride_next;
    end

endmodule

// File: hdl/ohi_queue.sv
// two entry command queue between front and back
`timescale 1ns / 1ps
module ohi_queue
    import ohi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        full = (count_reg == 2'd2);
        empty = (count_reg == 2'd0);
        pop_data = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/ohi_back.sv
// back end: table memories, probe sequencer, clear sweep and result register
`timescale 1ns / 1ps
module ohi_back
    import ohi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    output logic    q_pop,
    input  cmd_t    q_data,
    input  logic    q_empty,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic   occ_mem [TABLE_DEPTH];
    entry_t data_mem [TABLE_DEPTH];
    logic   occ_q;
    entry_t data_q;

    back_state_t state_reg, state_next;

    cmd_t              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] inc_reg, inc_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              clr_pend_reg, clr_pend_next;
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg, res_next;

    logic              occ_we;
    logic [ADDR_W-1:0] occ_waddr;
    logic              occ_wdata;
    logic              data_we;
    entry_t            data_wdata;
    logic              last_probe;
    logic [SIZE_W-1:0] idx_sum;
    logic [SIZE_W-1:0] inc_sum;
    logic [SIZE_W-1:0] idx_adv;
    logic [SIZE_W-1:0] inc_adv;

    assign q_pop = (state_reg == B_IDLE) && !q_empty && !out_valid_reg;
    assign last_probe = (cnt_reg + SIZE_W'(1)) == cmd_reg.tsize;
    assign out_valid = out_valid_reg;
    assign out_data = res_reg;

    // both operands stay below t, so one subtract brings the sum back
    assign idx_sum = {1'b0, idx_reg} + {1'b0, inc_reg};
    assign inc_sum = {1'b0, inc_reg} + {1'b0, cmd_reg.inc_step};
    assign idx_adv = (idx_sum >= cmd_reg.tsize) ? idx_sum - cmd_reg.tsize : idx_sum;
    assign inc_adv = (inc_sum >= cmd_reg.tsize) ? inc_sum - cmd_reg.tsize : inc_sum;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_SWEEP:
            begin
                if (sweep_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_pop)
                begin
                    priority if (q_data.op == OP_INSERT)
                    begin
                        state_next = B_PROBE_RD;
                    end
                    else if (q_data.op == OP_CLEAR)
                    begin
                        state_next = B_SWEEP;
                    end
                    else if (q_data.op == OP_READ)
                    begin
                        state_next = B_READ_WAIT;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_PROBE_RD:
            begin
                state_next = B_PROBE_CHK;
            end
            B_PROBE_CHK:
            begin
                state_next = (!occ_q || last_probe) ? B_IDLE : B_PROBE_RD;
            end
            B_READ_WAIT:
            begin
                state_next = B_READ_DONE;
            end
            B_READ_DONE:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        inc_next = inc_reg;
        cnt_next = cnt_reg;
        sweep_next = sweep_reg;
        clr_pend_next = clr_pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next = res_reg;
        occ_we = 1'b0;
        occ_waddr = idx_reg;
        occ_wdata = 1'b0;
        data_we = 1'b0;
        data_wdata.key_low = cmd_reg.key_low;
        data_wdata.key_high = cmd_reg.key_high;
        data_wdata.key_length = cmd_reg.key_length;
        data_wdata.record_tag = cmd_reg.record_tag;
        data_wdata.home_hash = cmd_reg.home_hash;
        unique case (state_reg)
            B_SWEEP:
            begin
                occ_we = 1'b1;
                occ_waddr = sweep_reg;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    clr_pend_next = 1'b0;
                    if (clr_pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        res_next = '0;
                    end
                end
            end
            B_IDLE:
            begin
                if (q_pop)
                begin
                    cmd_next = q_data;
                    cnt_next = '0;
                    inc_next = q_data.inc;
                    sweep_next = '0;
                    idx_next = (q_data.op == OP_READ) ? q_data.read_slot : q_data.home_hash;
                    if (q_data.op == OP_CLEAR)
                    begin
                        clr_pend_next = 1'b1;
                    end
                    else if (q_data.op != OP_INSERT && q_data.op != OP_READ)
                    begin
                        out_valid_next = 1'b1;
                        res_next = '0;
                    end
                end
            end
            B_PROBE_RD:
            begin
            end
            B_PROBE_CHK:
            begin
                if (!occ_q)
                begin
                    occ_we = 1'b1;
                    occ_wdata = 1'b1;
                    data_we = 1'b1;
                    out_valid_next = 1'b1;
                    res_next = '0;
                    res_next.slot_index = idx_reg;
                    res_next.home_hash = cmd_reg.home_hash;
                    res_next.probes = cnt_reg + SIZE_W'(1);
                    res_next.placed = 1'b1;
                end
                else if (last_probe)
                begin
                    // every probe found its slot in use
                    out_valid_next = 1'b1;
                    res_next = '0;
                    res_next.home_hash = cmd_reg.home_hash;
                    res_next.probes = cmd_reg.tsize;
                end
                else
                begin
                    cnt_next = cnt_reg + SIZE_W'(1);
                    idx_next = idx_adv[ADDR_W-1:0];
                    inc_next = inc_adv[ADDR_W-1:0];
                end
            end
            B_READ_WAIT:
            begin
            end
            B_READ_DONE:
            begin
                out_valid_next = 1'b1;
                res_next.slot_index = idx_reg;
                res_next.home_hash = data_q.home_hash;
                res_next.probes = '0;
                res_next.placed = 1'b0;
                res_next.occupied_flag = occ_q;
                res_next.stored_key_low = data_q.key_low;
                res_next.stored_key_high = data_q.key_high;
                res_next.stored_length = data_q.key_length;
                res_next.stored_tag = data_q.record_tag;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_SWEEP;
            sweep_reg <= '0;
            clr_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            clr_pend_reg <= clr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        inc_reg <= inc_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    // occupied marks
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        occ_q <= occ_mem[idx_reg];
    end

    // slot contents
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[idx_reg] <= data_wdata;
        end
        data_q <= data_mem[idx_reg];
    end

endmodule

// File: hdl/open_addressing_hash_insert.sv
// top level: configuration registers, front end, command queue and back end
`timescale 1ns / 1ps
// Open-addressing hash table of 1024 slots keyed by up to nine characters.
// The front end takes an item when idle; an insert does one multiply plus a
// bit-serial remainder against table_size and step_size for each key
// character, and then reduces the double hashing stride. The back end
// spends a read state and a check state on each probe, for the registered
// table read, and a read passes through a wait and a done state. A clear
// sweeps every slot at one per cycle, and the same sweep runs after reset
// before the first item is carried out. A two entry queue lets the front
// work on the next item while the back still probes.
module open_addressing_hash_insert
    import ohi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // key_low, key_high, key_length, record_tag, read_slot
    input  logic [1:0]   s_tuser,  // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // slot_index, home_hash, probes, placed, occupied_flag,
                                   // stored_key_low, stored_key_high, stored_length,
                                   // stored_tag
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_data
);

    logic              probe_mode_reg;
    logic [SIZE_W-1:0] table_size_reg;
    logic [SIZE_W-1:0] step_size_reg;

    logic    q_push;
    cmd_t    q_in;
    logic    q_full;
    logic    q_pop;
    cmd_t    q_out;
    logic    q_empty;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_mode_reg <= 1'b0;
            table_size_reg <= TABLE_SIZE_RST;
            step_size_reg <= STEP_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROBE_MODE: probe_mode_reg <= cfg_data[0];
                REG_TABLE_SIZE: table_size_reg <= cfg_data;
                REG_STEP_SIZE:  step_size_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ohi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tuser),
        .in_key_low    (s_tdata[63:0]),
        .in_key_high   (s_tdata[71:64]),
        .in_key_length (s_tdata[75:72]),
        .in_record_tag (s_tdata[91:76]),
        .in_read_slot  (s_tdata[101:92]),
        .probe_mode    (probe_mode_reg),
        .table_size    (table_size_reg),
        .step_size     (step_size_reg),
        .q_push        (q_push),
        .q_data        (q_in),
        .q_full        (q_full)
    );

    ohi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    ohi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_pop     (q_pop),
        .q_data    (q_out),
        .q_empty   (q_empty),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {3'b000, res};

endmodule

// File: sim/tb_open_addressing_hash_insert.sv
// testbench for the open addressing hash insert block: scoreboard, stimulus and checks
`timescale 1ns / 1ps
module tb_open_addressing_hash_insert;
    import ohi_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        logic [9:0]  slot_index;
        logic [9:0]  home_hash;
        logic [10:0] probes;
        logic        placed;
        logic        occupied_flag;
        logic [63:0] stored_key_low;
        logic [7:0]  stored_key_high;
        logic [3:0]  stored_length;
        logic [15:0] stored_tag;
    } hash_result_t;

    class hash_scoreboard;
        bit          mode;
        logic [10:0] tsize_reg;
        logic [10:0] ssize_reg;
        bit          occ[TABLE_DEPTH];
        bit          written[TABLE_DEPTH];
        logic [63:0] klo_mem[TABLE_DEPTH];
        logic [7:0]  khi_mem[TABLE_DEPTH];
        logic [3:0]  len_mem[TABLE_DEPTH];
        logic [15:0] tag_mem[TABLE_DEPTH];
        logic [9:0]  hash_mem[TABLE_DEPTH];
        int          written_slots[$];
        hash_result_t pending_q[$];
        int          fails;

        function new();
            mode = 0;
            tsize_reg = TABLE_SIZE_RST;
            ssize_reg = STEP_SIZE_RST;
            fails = 0;
            foreach (occ[i])
            begin
                occ[i] = 0;
                written[i] = 0;
            end
        endfunction

        function int key_mod(logic [63:0] klo, logic [7:0] khi, int len, int m);
            int acc;
            int c;
            acc = 1 % m;
            for (int n = 0; n < len; n++)
            begin
                c = (n < 8) ? int'(klo[8*n +: 8]) : int'(khi);
                acc = (acc * c) % m;
            end
            return acc;
        endfunction

        function void note_input(logic [1:0] op, logic [63:0] klo, logic [7:0] khi,
                                 logic [3:0] klen, logic [15:0] tag, logic [9:0] rslot);
            hash_result_t r;
            int t;
            int s;
            int len;
            int h;
            int stride;
            int idx;
            int cnt;
            int slot;
            bit found;
            r = '{default: '0};
            if (op == OP_INSERT)
            begin
                t = tsize_reg;
                s = ssize_reg;
                if (t < 2) t = 2;
                if (t > TABLE_DEPTH) t = TABLE_DEPTH;
                if (s < 2) s = 2;
                len = (klen > KEY_CHARS) ? KEY_CHARS : klen;
                h = key_mod(klo, khi, len, t);
                stride = s - key_mod(klo, khi, len, s);
                idx = h;
                found = 0;
                slot = 0;
                cnt = 0;
                while (cnt < t && !found)
                begin
                    if (!mode)
                        idx = (h + cnt * cnt) % t;
                    else if (cnt > 0)
                        idx = (idx + stride) % t;
                    if (!occ[idx])
                    begin
                        found = 1;
                        slot = idx;
                    end
                    cnt++;
                end
                if (found)
                begin
                    occ[slot] = 1;
                    klo_mem[slot] = klo;
                    khi_mem[slot] = khi;
                    len_mem[slot] = len;
                    tag_mem[slot] = tag;
                    hash_mem[slot] = h;
                    if (!written[slot])
                        written_slots.push_back(slot);
                    written[slot] = 1;
                end
                r.slot_index = slot;
                r.home_hash = h;
                r.probes = cnt;
                r.placed = found;
            end
            else if (op == OP_CLEAR)
            begin
                foreach (occ[i])
                    occ[i] = 0;
            end
            else if (op == OP_READ)
            begin
                r.slot_index = rslot;
                r.home_hash = hash_mem[rslot];
                r.occupied_flag = occ[rslot];
                r.stored_key_low = klo_mem[rslot];
                r.stored_key_high = khi_mem[rslot];
                r.stored_length = len_mem[rslot];
                r.stored_tag = tag_mem[rslot];
            end
            pending_q.push_back(r);
        endfunction

        function void field_cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
                fails++;
            end
        endfunction

        function void check_result(hash_result_t a);
            hash_result_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none, actual slot %0h",
                         $time, a.slot_index);
                fails++;
                return;
            end
            e = pending_q.pop_front();
            field_cmp("slot_index", e.slot_index, a.slot_index);
            field_cmp("home_hash", e.home_hash, a.home_hash);
            field_cmp("probes", e.probes, a.probes);
            field_cmp("placed", e.placed, a.placed);
            field_cmp("occupied_flag", e.occupied_flag, a.occupied_flag);
            field_cmp("stored_key_low", e.stored_key_low, a.stored_key_low);
            field_cmp("stored_key_high", e.stored_key_high, a.stored_key_high);
            field_cmp("stored_length", e.stored_length, a.stored_length);
            field_cmp("stored_tag", e.stored_tag, a.stored_tag);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [10:0]  cfg_data;

    hash_scoreboard sb;
    int  send_idle;
    int  recv_idle;
    bit  hold_req;
    int  hold_cnt;
    int  quiet_cycles;

    open_addressing_hash_insert dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // result side: check, random ready, long hold-off and watchdog
    always @(posedge clk)
    begin
        hash_result_t a;
        if (m_tvalid && m_tready)
        begin
            a.slot_index = m_tdata[9:0];
            a.home_hash = m_tdata[19:10];
            a.probes = m_tdata[30:20];
            a.placed = m_tdata[31];
            a.occupied_flag = m_tdata[32];
            a.stored_key_low = m_tdata[96:33];
            a.stored_key_high = m_tdata[104:97];
            a.stored_length = m_tdata[108:105];
            a.stored_tag = m_tdata[124:109];
            sb.check_result(a);
        end
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("tb_open_addressing_hash_insert NOT OK");
            $finish;
        end
        if (hold_req && hold_cnt == 0)
        begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_item(logic [1:0] op, logic [63:0] klo, logic [7:0] khi,
                             logic [3:0] klen, logic [15:0] tag, logic [9:0] rslot);
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b0, rslot, tag, klen, khi, klo};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(op, klo, khi, klen, tag, rslot);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_config(bit mode, logic [10:0] tsz, logic [10:0] ssz);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_PROBE_MODE;
        cfg_data <= {10'b0, mode};
        @(posedge clk);
        cfg_index <= REG_TABLE_SIZE;
        cfg_data <= tsz;
        @(posedge clk);
        cfg_index <= REG_STEP_SIZE;
        cfg_data <= ssz;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.mode = mode;
        sb.tsize_reg = tsz;
        sb.ssize_reg = ssz;
    endtask

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        // zero or all-ones characters now and then
        if ($urandom_range(7) == 0)
            k[8*$urandom_range(7) +: 8] = 8'h00;
        if ($urandom_range(7) == 0)
            k[8*$urandom_range(7) +: 8] = 8'hFF;
        return k;
    endfunction

    task automatic send_random();
        int r;
        logic [1:0] op;
        logic [9:0] rslot;
        r = $urandom_range(99);
        rslot = $urandom_range(1023);
        if (r < 72)
            op = OP_INSERT;
        else if (r < 95)
            op = OP_READ;
        else if (r < 97)
            op = OP_CLEAR;
        else
            op = OP_NOP;
        if (op == OP_READ)
        begin
            // only slots some insert has written
            if (sb.written_slots.size() == 0)
                op = OP_INSERT;
            else
                rslot = sb.written_slots[$urandom_range(sb.written_slots.size() - 1)];
        end
        send_item(op, rand_key(), $urandom_range(255), $urandom_range(15),
                  $urandom_range(65535), rslot);
    endtask

    task automatic directed_part(bit mode);
        set_config(mode, 11'd5, 11'd3);
        send_item(OP_INSERT, 64'h0, 8'h0, 4'd0, 16'h0, 10'h0);
        send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 4'd9, 16'hFFFF, 10'h3FF);
        send_item(OP_INSERT, 64'h0102_0304_0506_0708, 8'h09, 4'd15, 16'h1234, 10'h155);
        send_item(OP_INSERT, 64'h4142_0043_4445_4647, 8'h48, 4'd8, 16'h8001, 10'h2AA);
        send_item(OP_INSERT, 64'h3, 8'h0, 4'd1, 16'h00FF, 10'h0);
        // table full or close to it
        send_item(OP_INSERT, 64'h7, 8'h0, 4'd1, 16'hAAAA, 10'h0);
        for (int i = 0; i < 5; i++)
            send_item(OP_READ, 64'h0, 8'h0, 4'd0, 16'h0, i[9:0]);
        send_item(OP_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 4'hF, 16'hFFFF, 10'h3FF);
        send_item(OP_CLEAR, 64'h0, 8'h0, 4'd0, 16'h0, 10'h0);
        send_item(OP_READ, 64'h0, 8'h0, 4'd0, 16'h0, 10'd2);
        send_item(OP_INSERT, 64'h0000_0000_0000_0505, 8'h0, 4'd2, 16'h5555, 10'h0);
        send_item(OP_READ, 64'h0, 8'h0, 4'd0, 16'h0, 10'd0);
        drain();
    endtask

    typedef struct {
        bit          mode;
        logic [10:0] tsz;
        logic [10:0] ssz;
    } phase_cfg_t;

    initial
    begin
        phase_cfg_t phases[10];
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_INSERT;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PROBE_MODE;
        cfg_data = '0;
        send_idle = 15;
        recv_idle = 78;
        hold_req = 0;
        hold_cnt = 0;
        quiet_cycles = 0;
        phases = '{'{0, 1021, 509}, '{1, 1021, 509}, '{0, 1024, 1021}, '{1, 2, 2},
                   '{0, 7, 5}, '{1, 13, 11}, '{0, 31, 29}, '{1, 101, 97},
                   '{0, 0, 0}, '{1, 2047, 1}};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset defaults first, then the extremes of the table
        send_item(OP_INSERT, 64'h0000_0000_0063_6261, 8'h0, 4'd3, 16'h0042, 10'h0);
        drain();
        directed_part(0);
        directed_part(1);
        for (int p = 0; p < 10; p++)
        begin
            if (p < 3)
            begin
                send_idle = 15;
                recv_idle = 78;
            end
            else if (p < 6)
            begin
                send_idle = 78;
                recv_idle = 15;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            set_config(phases[p].mode, phases[p].tsz, phases[p].ssz);
            if (p == 0)
                hold_req = 1;
            repeat (75) send_random();
            drain();
        end
        if (sb.fails == 0)
            $display("tb_open_addressing_hash_insert OK");
        else
            $display("tb_open_addressing_hash_insert NOT OK");
        $finish;
    end

endmodule
